/* sv/ssbi_pkg.sv */
// Package for the sorted/bottom-insert stack: word types, operation and
// status codes, and the control structs shared by the cell row and top level.
// No dependencies.
package ssbi_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned COUNT_W = 5;   // width of the reported entry count

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TOP    = 3'd0,
    OP_INSERT      = 3'd1,
    OP_PUSH_BOTTOM = 3'd2,
    OP_POP         = 3'd3,
    OP_PEEK        = 3'd4,
    OP_FIND        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_PUSH_TOP,
    MODE_SHIFT_BOTTOM,
    MODE_INSERT
  } cell_mode_t;

  typedef enum logic {
    FSM_ACCEPT,
    FSM_REPORT
  } fsm_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic                     found;
    logic [COUNT_W-1:0]       entry_count;
    logic [1:0]               status;
  } rsp_word_t;

  // Broadcast to every cell.
  typedef struct packed {
    cell_mode_t               mode;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  // Where a cell sits relative to the current fill level.
  typedef struct packed {
    logic occupied;   // index below the count
    logic at_count;   // index equals the count (first free slot)
    logic is_top;     // index equals count - 1
  } cell_pos_t;

  // Accumulated bottom to top through the row.
  typedef struct packed {
    logic                     found;
    logic                     dup;
    logic signed [DATA_W-1:0] top_value;
  } chain_t;

endpackage

/* sv/ssbi_cell.sv */
// One stack entry with its comparators and neighbor links.
// Depends on ssbi_pkg.
module ssbi_cell (
  input  logic                             clk,
  input  ssbi_pkg::cell_ctl_t              ctl,
  input  ssbi_pkg::cell_pos_t              pos,
  input  logic signed [ssbi_pkg::DATA_W-1:0] below_data,
  input  logic                             below_le,
  input  logic                             above_le_any,
  output logic signed [ssbi_pkg::DATA_W-1:0] data,
  output logic                             le,
  output logic                             le_any,
  input  ssbi_pkg::chain_t                 chain_in,
  output ssbi_pkg::chain_t                 chain_out
);
  import ssbi_pkg::*;

  logic signed [DATA_W-1:0] data_next;
  logic                     eq;
  logic                     in_range;

  assign eq       = (data == ctl.value);
  assign le       = pos.occupied && (data <= ctl.value);
  assign le_any   = le | above_le_any;
  assign in_range = pos.occupied | pos.at_count;

  assign chain_out.found     = chain_in.found | (pos.occupied & eq);
  // the insertion point sits just above the highest entry not greater than the value
  assign chain_out.dup       = chain_in.dup | (le & ~above_le_any & eq);
  assign chain_out.top_value = chain_in.top_value | (pos.is_top ? data : '0);

  always_comb begin
    data_next = data;
    case (ctl.mode)
      MODE_PUSH_TOP: begin
        if (pos.at_count) data_next = ctl.value;
      end
      MODE_SHIFT_BOTTOM: begin
        if (in_range) data_next = below_data;
      end
      MODE_INSERT: begin
        // shift up everything above the insertion point; the slot itself takes the value
        if (in_range && !le_any) data_next = below_le ? ctl.value : below_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* sv/stack_with_sorted_and_bottom_insert_top.sv */
// Bounded stack of signed 32-bit words with push top, push bottom, sorted insert,
// pop, peek and find. A request word is not accepted until the previous response
// word has been loaded. The entry row is written at the end of the accept cycle and
// the top entry is read out in the report state, which waits while rsp is stalled.
// Reset (rst, synchronous, active high) empties the stack and clears the
// handshake; entry contents are left as they are.
module stack_with_sorted_and_bottom_insert_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ssbi_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ssbi_pkg::rsp_word_t rsp
);
  import ssbi_pkg::*;

  // count must reach DEPTH itself
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Control and fill level
  fsm_t             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             accept;
  logic             full;
  logic             empty;

  // Results held between the update and the report
  logic    found_hold, found_hold_next;
  status_t status_hold, status_hold_next;

  // Output register
  logic      rsp_valid_next;
  rsp_word_t rsp_next;
  logic      rsp_load;

  cell_ctl_t ctl;

  // Cell row links
  logic signed [DATA_W-1:0] data_w   [DEPTH];
  logic                     le_w     [DEPTH];
  logic                     le_any_w [DEPTH+1];
  chain_t                   chain_w  [DEPTH+1];

  logic dup;
  logic found;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  assign le_any_w[DEPTH] = 1'b0;
  assign chain_w[0]      = '0;
  assign dup             = chain_w[DEPTH].dup;
  assign found           = chain_w[DEPTH].found;

  // Cell 0 sees the incoming value as its lower neighbor, so a bottom push
  // and an insert at the bottom both drop the value into it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_pos_t                pos;
    logic signed [DATA_W-1:0] below_data;
    logic                     below_le;

    assign pos.occupied = (CNT_W'(i) < count);
    assign pos.at_count = (count == CNT_W'(i));
    assign pos.is_top   = (count == CNT_W'(i + 1));

    if (i == 0) begin : g_bottom
      assign below_data = req.value;
      assign below_le   = 1'b1;
    end else begin : g_upper
      assign below_data = data_w[i-1];
      assign below_le   = le_w[i-1];
    end

    ssbi_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .pos          (pos),
      .below_data   (below_data),
      .below_le     (below_le),
      .above_le_any (le_any_w[i+1]),
      .data         (data_w[i]),
      .le           (le_w[i]),
      .le_any       (le_any_w[i]),
      .chain_in     (chain_w[i]),
      .chain_out    (chain_w[i+1])
    );
  end

  // Hold off new requests while the previous result is being reported.
  assign req_stall = (state == FSM_REPORT);
  assign accept    = req_valid && (state == FSM_ACCEPT);
  assign rsp_load  = (state == FSM_REPORT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next       = state;
    count_next       = count;
    found_hold_next  = found_hold;
    status_hold_next = status_hold;
    ctl.mode         = MODE_HOLD;
    ctl.value        = req.value;
    rsp_valid_next   = rsp_valid;
    rsp_next         = rsp;

    if (rsp_valid && !rsp_stall) rsp_valid_next = 1'b0;

    case (state)
      FSM_ACCEPT: begin
        if (accept) begin
          found_hold_next  = 1'b0;
          status_hold_next = ST_DONE;
          case (req.operation)
            OP_PUSH_TOP: begin
              if (full) begin
                status_hold_next = ST_FULL;
              end else begin
                ctl.mode   = MODE_PUSH_TOP;
                count_next = count + 1'b1;
              end
            end
            OP_INSERT: begin
              // a duplicate wins over a full stack
              if (dup) begin
                status_hold_next = ST_DUP;
              end else if (full) begin
                status_hold_next = ST_FULL;
              end else begin
                ctl.mode   = MODE_INSERT;
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_BOTTOM: begin
              if (full) begin
                status_hold_next = ST_FULL;
              end else begin
                ctl.mode   = MODE_SHIFT_BOTTOM;
                count_next = count + 1'b1;
              end
            end
            OP_POP: begin
              if (empty) status_hold_next = ST_EMPTY;
              else       count_next       = count - 1'b1;
            end
            OP_FIND: begin
              found_hold_next = found;
            end
            default: begin
              // peek and unused codes leave the stack alone
            end
          endcase
          state_next = FSM_REPORT;
        end
      end
      FSM_REPORT: begin
        // the row now holds the updated entries; read the top and report
        if (rsp_load) begin
          rsp_valid_next       = 1'b1;
          rsp_next.top_value   = empty ? -32'sd1 : chain_w[DEPTH].top_value;
          rsp_next.found       = found_hold;
          rsp_next.entry_count = COUNT_W'(count);
          rsp_next.status      = status_hold;
          state_next           = FSM_ACCEPT;
        end
      end
      default: begin
        state_next = FSM_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_ACCEPT;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    found_hold  <= found_hold_next;
    status_hold <= status_hold_next;
    rsp         <= rsp_next;
  end

endmodule

/* tb/tb_stack_with_sorted_and_bottom_insert_top.sv */
// Self-checking testbench for stack_with_sorted_and_bottom_insert_top.
// Drives request words through valid/stall and checks each response word
// against a shadow model of the stack. Depends on ssbi_pkg and the top module.
`timescale 1ns / 100ps

module tb_stack_with_sorted_and_bottom_insert_top;
  import ssbi_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no word accepted
  localparam int unsigned HOLD_OFF_CYCLES = 200;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 10;      // extra clocks run after the last response

  // Operation codes the package leaves unnamed; the block treats them as peek.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_word_t rsp;

  stack_with_sorted_and_bottom_insert_top #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the stack: index 0 is the bottom.
  logic signed [DATA_W-1:0] shadow_entries [STACK_DEPTH];
  int unsigned              shadow_count;

  // Responses predicted for accepted requests, oldest first.
  rsp_word_t predicted_rsp_q [$];

  int unsigned mismatch_count;
  int unsigned idle_cycles;

  // Idling controls shared by the test tasks and the receiver.
  bit          send_idle_on;
  bit          recv_idle_on;
  bit          hold_req;
  int unsigned hold_left;

  // Open a gap at pos by moving the entries above it up one place.
  function automatic void shadow_insert(int unsigned pos, logic signed [DATA_W-1:0] v);
    for (int unsigned i = shadow_count; i > pos; i--)
      shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[pos] = v;
    shadow_count++;
  endfunction

  // Apply one request word to the shadow stack and return the response word.
  function automatic rsp_word_t stack_apply(req_word_t w);
    rsp_word_t   r;
    int unsigned pos;
    logic        full;
    r        = '0;
    r.status = ST_DONE;
    full     = (shadow_count >= STACK_DEPTH);
    case (w.operation)
      OP_PUSH_TOP: begin
        if (full) r.status = ST_FULL;
        else shadow_insert(shadow_count, w.value);
      end
      OP_INSERT: begin
        // Walk down past the run of top entries greater than the value.
        pos = shadow_count;
        while (pos > 0 && $signed(shadow_entries[pos-1]) > $signed(w.value))
          pos--;
        // Duplicate check wins over the full check.
        if (pos > 0 && shadow_entries[pos-1] == w.value) r.status = ST_DUP;
        else if (full) r.status = ST_FULL;
        else shadow_insert(pos, w.value);
      end
      OP_PUSH_BOTTOM: begin
        if (full) r.status = ST_FULL;
        else shadow_insert(0, w.value);
      end
      OP_POP: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < shadow_count; i++)
          if (shadow_entries[i] == w.value) r.found = 1'b1;
      end
      default: ;  // peek and the spare codes leave the stack alone
    endcase
    r.top_value   = (shadow_count > 0) ? shadow_entries[shadow_count-1] : -32'sd1;
    r.entry_count = COUNT_W'(shadow_count);
    return r;
  endfunction

  // Predict on every accepted request word, check every accepted response word.
  // Both handshakes are sampled at the edge, before any driven value moves.
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst) begin
      if (req_valid && !req_stall)
        predicted_rsp_q.push_back(stack_apply(req));
      if (rsp_valid && !rsp_stall) begin
        if (predicted_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response word: top %0d found %0b count %0d status %0d",
                     rsp.top_value, rsp.found, rsp.entry_count, rsp.status);
        end else begin
          want = predicted_rsp_q.pop_front();
          if (rsp.top_value !== want.top_value || rsp.found !== want.found ||
              rsp.entry_count !== want.entry_count || rsp.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("response mismatch: expected top %0d found %0b count %0d status %0d,",
                       want.top_value, want.found, want.entry_count, want.status);
              $display("  got top %0d found %0b count %0d status %0d",
                       rsp.top_value, rsp.found, rsp.entry_count, rsp.status);
            end
          end
        end
      end
    end
  end

  // Receiver: hold off for a counted stretch on request, otherwise stall at random while receiver idling is on.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if (!recv_idle_on) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one request word and hold it until accepted. Valid stays high on
  // return so that a following word goes out back to back.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
    req_word_t w;
    int unsigned gap;
    w.operation = op;
    w.value     = v;
    if (send_idle_on && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every predicted response word has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (predicted_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Data word mix: small values for duplicates and hits, extremes, held values,
  // and full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom();
    if (r < 35) begin
      case ($urandom_range(0, 4))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return -32'sd1;
        3: return 32'sd0;
        default: return 32'sd1;
      endcase
    end
    if (r < 75 || shadow_count == 0) return $signed($urandom_range(0, 16)) - 32'sd8;
    return shadow_entries[$urandom_range(0, shadow_count - 1)];
  endfunction

  // Hit every operation and special case on a known stack.
  task automatic test_directed_edges();
    // Empty stack: pop of empty, peek, find, spare codes.
    send_word(OP_POP, 32'sd0);
    send_word(OP_PEEK, 32'sd0);
    send_word(OP_FIND, 32'sd0);
    send_word(OP_SPARE_6, VAL_MAX);
    send_word(OP_SPARE_7, VAL_MIN);
    // Sorted insert into empty, below all, above all, duplicate, middle.
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, VAL_MIN);
    send_word(OP_INSERT, VAL_MAX);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_PUSH_BOTTOM, 32'sd0);
    send_word(OP_FIND, VAL_MIN);
    send_word(OP_FIND, 32'sd7);
    send_word(OP_POP, 32'sd0);
    send_word(OP_PUSH_TOP, VAL_MAX);
    // Fill to the brim with ascending words, then hit the full cases.
    for (int i = 0; i < 10; i++) send_word(OP_PUSH_TOP, 32'sd100 + i);
    send_word(OP_PUSH_TOP, VAL_MIN);
    send_word(OP_PUSH_BOTTOM, VAL_MAX);
    send_word(OP_INSERT, 32'sd200);   // not a duplicate: dropped as full
    send_word(OP_INSERT, 32'sd109);   // 109 is present but below the top word: not a duplicate, dropped as full
    send_word(OP_FIND, 32'sd109);
  endtask

  // Random operations over all codes, drifting between filling and draining.
  task automatic test_mixed_traffic(input int unsigned n);
    bit          filling;
    int unsigned r;
    logic [OP_W-1:0] op;
    filling = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (shadow_count >= STACK_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (shadow_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 25) op = OP_PUSH_TOP;
        else if (r < 50) op = OP_INSERT;
        else if (r < 62) op = OP_PUSH_BOTTOM;
        else if (r < 72) op = OP_POP;
        else if (r < 85) op = OP_FIND;
        else if (r < 93) op = OP_PEEK;
        else op = OP_W'($urandom_range(0, 7));
      end else begin
        if (r < 45) op = OP_POP;
        else if (r < 55) op = OP_PUSH_TOP;
        else if (r < 65) op = OP_INSERT;
        else if (r < 70) op = OP_PUSH_BOTTOM;
        else if (r < 85) op = OP_FIND;
        else if (r < 93) op = OP_PEEK;
        else op = OP_W'($urandom_range(0, 7));
      end
      send_word(op, pick_value());
    end
  endtask

  // Long runs of sorted inserts over a narrow window, so duplicates are common;
  // drain with a burst of pops once the stack is full.
  task automatic test_sorted_runs(input int unsigned n);
    int unsigned r;
    int unsigned burst;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (shadow_count >= STACK_DEPTH && r < 20) begin
        burst = $urandom_range(1, STACK_DEPTH + 1);
        for (int unsigned k = 0; k < burst; k++) send_word(OP_POP, $urandom());
        i += burst;
      end else if (r < 75) begin
        send_word(OP_INSERT, $signed($urandom_range(0, 24)) - 32'sd12);
      end else if (r < 87) begin
        send_word(OP_FIND, pick_value());
      end else if (r < 95) begin
        send_word(OP_POP, $urandom());
      end else begin
        send_word(OP_PEEK, $urandom());
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up
  // and stalls its input; then the sender pauses until everything is back.
  task automatic test_backpressure(input int unsigned n);
    hold_req = 1'b1;
    test_mixed_traffic(n);
    wait_drained();
  endtask

  // Back-to-back words with neither side idling.
  task automatic test_no_idle(input int unsigned n);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_mixed_traffic(n);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin
    // Known values on every input from time zero; empty shadow stack.
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    rsp_stall      = 1'b0;
    shadow_count   = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    send_idle_on   = 1'b1;
    recv_idle_on   = 1'b1;
    for (int i = 0; i < STACK_DEPTH; i++) shadow_entries[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_mixed_traffic(800);
    test_sorted_runs(400);
    test_backpressure(60);
    test_no_idle(300);
    test_mixed_traffic(60);

    // Let everything come back, then run the clock on for DRAIN_CYCLES.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && predicted_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (predicted_rsp_q.size() != 0)
        $display("%0d response words never arrived", predicted_rsp_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
